// ===== rtl/core/modbus_rtu_request_framer_defines.svh =====
// Assertion macros for the Modbus RTU request framer.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/mrf_pkg.sv =====
`default_nettype none

package mrf_pkg;

    localparam int FrameLen   = 8;
    localparam int IdxW       = $clog2(FrameLen);
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [IdxW-1:0] PosAddr    = IdxW'(0);
    localparam logic [IdxW-1:0] PosFunc    = IdxW'(1);
    localparam logic [IdxW-1:0] PosRegHi   = IdxW'(2);
    localparam logic [IdxW-1:0] PosRegLo   = IdxW'(3);
    localparam logic [IdxW-1:0] PosValHi   = IdxW'(4);
    localparam logic [IdxW-1:0] PosValLo   = IdxW'(5);
    localparam logic [IdxW-1:0] PosCrcLo   = IdxW'(6);
    localparam logic [IdxW-1:0] PosCrcHi   = IdxW'(7);

    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] register_value;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrf_front.sv =====
`default_nettype none

module mrf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mrf_pkg::t_req      i_req,
    input  wire mrf_pkg::t_q_status i_q_status,
    output logic                    o_push,
    output mrf_pkg::t_req           o_req
);

    logic          r_valid;
    logic          n_valid;
    mrf_pkg::t_req r_req;
    logic          w_accept;

    assign o_in_stall = r_valid && i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_req      = r_req;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_queue.sv =====
`default_nettype none

module mrf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mrf_pkg::t_req      i_req,
    input  wire logic               i_pop,
    output mrf_pkg::t_req           o_req,
    output mrf_pkg::t_q_status      o_status
);

    mrf_pkg::t_req                   r_mem [mrf_pkg::QueueDepth];
    logic [mrf_pkg::QPtrW-1:0]       r_wr_ptr;
    logic [mrf_pkg::QPtrW-1:0]       r_rd_ptr;
    logic [mrf_pkg::QCntW-1:0]       r_count;

    assign o_req          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == mrf_pkg::QCntW'(mrf_pkg::QueueDepth));
    assign o_status.empty = (r_count == '0);

    function automatic logic [mrf_pkg::QPtrW-1:0] ptr_inc(
            input logic [mrf_pkg::QPtrW-1:0] p);
        logic [mrf_pkg::QPtrW-1:0] q;
        if (p == mrf_pkg::QPtrW'(mrf_pkg::QueueDepth - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_back.sv =====
`default_nettype none

module mrf_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mrf_pkg::t_req      i_req,
    input  wire mrf_pkg::t_q_status i_q_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [7:0]              o_frame_byte,
    output logic                    o_last_byte
);

    mrf_pkg::t_req                r_req;
    logic                         r_busy;
    logic [mrf_pkg::IdxW-1:0]     r_idx;
    logic [15:0]                  r_crc;
    logic                         r_out_valid;
    logic [7:0]                   r_byte;
    logic                         r_last;

    logic                         w_adv;
    logic                         w_emit;
    logic                         w_end;
    logic [7:0]                   w_byte;
    logic                         w_data_pos;

    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_emit = r_busy && w_adv;
    assign w_end  = w_emit && (r_idx == mrf_pkg::PosCrcHi);
    assign o_pop  = !i_q_status.empty && (!r_busy || w_end);

    always_comb begin
        w_data_pos = 1'b1;
        unique case (r_idx)
            mrf_pkg::PosAddr:  w_byte = r_req.device_address;
            mrf_pkg::PosFunc:  w_byte = r_req.function_code;
            mrf_pkg::PosRegHi: w_byte = r_req.register_address[15:8];
            mrf_pkg::PosRegLo: w_byte = r_req.register_address[7:0];
            mrf_pkg::PosValHi: w_byte = r_req.register_value[15:8];
            mrf_pkg::PosValLo: w_byte = r_req.register_value[7:0];
            mrf_pkg::PosCrcLo: begin
                w_byte     = r_crc[7:0];
                w_data_pos = 1'b0;
            end
            default: begin
                w_byte     = r_crc[15:8];
                w_data_pos = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_emit) begin
                r_busy <= !w_end;
                r_idx  <= r_idx + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_adv) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_req;
            r_crc <= mrf_pkg::CrcInit;
        end else if (w_emit && w_data_pos) begin
            r_crc <= mrf_pkg::crc_update(r_crc, w_byte);
        end
        if (w_emit) begin
            r_byte <= w_byte;
            r_last <= (r_idx == mrf_pkg::PosCrcHi);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/modbus_rtu_request_framer.sv =====
// Modbus RTU request framer: one request word in, eight frame byte words out.
// Each request passes the front register, the queue and the serializer before its first byte is output.
// The serializer pops the next request as it emits a frame's last byte, unless the output stalls.
// A two-entry queue lets up to three requests be taken while a frame is sent.
// Reset (i_rst_n low, synchronous) empties front, queue and serializer.
`default_nettype none
`include "modbus_rtu_request_framer_defines.svh"

module modbus_rtu_request_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_device_address,
    input  wire logic [7:0]  i_function_code,
    input  wire logic [15:0] i_register_address,
    input  wire logic [15:0] i_register_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte
);

    mrf_pkg::t_req      w_in_req;
    mrf_pkg::t_req      w_push_req;
    mrf_pkg::t_req      w_head_req;
    mrf_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    assign w_in_req.device_address   = i_device_address;
    assign w_in_req.function_code    = i_function_code;
    assign w_in_req.register_address = i_register_address;
    assign w_in_req.register_value   = i_register_value;

    mrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (w_in_req),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_req      (w_push_req)
    );

    mrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_req    (w_push_req),
        .i_pop    (w_pop),
        .o_req    (w_head_req),
        .o_status (w_q_status)
    );

    mrf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_head_req),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    `MRF_ASSERT_SAME(a_full_not_empty, i_clk, i_rst_n, w_q_status.full, !w_q_status.empty)
    `MRF_ASSERT_SAME(a_pop_has_data, i_clk, i_rst_n, w_pop, !w_q_status.empty)
    `MRF_ASSERT_SAME(a_push_has_room, i_clk, i_rst_n, w_push, !w_q_status.full)

endmodule

`default_nettype wire

// ===== dv/modbus_rtu_request_framer_test.sv =====
`timescale 1ns / 1ps

module modbus_rtu_request_framer_test;

    localparam int CycleLimit = 200000;
    localparam logic [15:0] ModbusPoly = 16'hA001;
    localparam logic [7:0] FnReadHolding = 8'h03;
    localparam logic [7:0] FnWriteSingle = 8'h06;
    localparam logic [7:0] FnReadInput = 8'h04;
    localparam logic [7:0] FnWriteMulti = 8'h10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    class frame_scoreboard;
        t_frame_byte pending_bytes[$];
        int          mismatches;
        int          frames_sent;
        int          bytes_seen;

        function new();
            mismatches  = 0;
            frames_sent = 0;
            bytes_seen  = 0;
        endfunction

        function void note_request(mrf_pkg::t_req r);
            logic [7:0]  fb [8];
            logic [15:0] crc;
            t_frame_byte e;
            fb[0] = r.device_address;
            fb[1] = r.function_code;
            fb[2] = r.register_address[15:8];
            fb[3] = r.register_address[7:0];
            fb[4] = r.register_value[15:8];
            fb[5] = r.register_value[7:0];
            // bitwise form: shift out LSB, fold in poly when feedback is set
            crc = 16'hFFFF;
            for (int i = 0; i < 6; i++) begin
                for (int k = 0; k < 8; k++) begin
                    if (crc[0] ^ fb[i][k]) begin
                        crc = (crc >> 1) ^ ModbusPoly;
                    end else begin
                        crc = crc >> 1;
                    end
                end
            end
            fb[6] = crc[7:0];
            fb[7] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
                e.data = fb[i];
                e.last = (i == 7);
                pending_bytes.insert(pending_bytes.size(), e);
            end
            frames_sent++;
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_frame_byte e;
            bytes_seen++;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %02h last=%b", data, last);
                return;
            end
            e = pending_bytes.pop_front();
            if (data !== e.data || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte %0d: expected %02h last=%b, got %02h last=%b",
                             bytes_seen, e.data, e.last, data, last);
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_device_address;
    logic [7:0]  i_function_code;
    logic [15:0] i_register_address;
    logic [15:0] i_register_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;

    int              in_idle_pct;
    int              out_stall_pct;
    int              cycles;
    frame_scoreboard sb;

    modbus_rtu_request_framer u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_device_address   (i_device_address),
        .i_function_code    (i_function_code),
        .i_register_address (i_register_address),
        .i_register_value   (i_register_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame_byte       (o_frame_byte),
        .o_last_byte        (o_last_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d bytes outstanding", cycles, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_byte(o_frame_byte, o_last_byte);
    end

    function automatic mrf_pkg::t_req make_req(logic [7:0] dev, logic [7:0] fn,
                                               logic [15:0] regaddr, logic [15:0] val);
        mrf_pkg::t_req r;
        r.device_address   = dev;
        r.function_code    = fn;
        r.register_address = regaddr;
        r.register_value   = val;
        return r;
    endfunction

    function automatic mrf_pkg::t_req random_req();
        mrf_pkg::t_req r;
        int            pick;
        pick = $urandom_range(99);
        r.device_address   = 8'($urandom_range(255));
        r.register_address = 16'($urandom_range(16'hFFFF));
        r.register_value   = 16'($urandom_range(16'hFFFF));
        if (pick < 40) begin
            r.function_code  = FnReadHolding;
            r.register_value = 16'($urandom_range(1, 125));
        end else if (pick < 70) begin
            r.function_code = FnWriteSingle;
        end else begin
            r.function_code = 8'($urandom_range(255));
        end
        if (pick >= 95)
            r.register_address = (pick[0]) ? 16'hFFFF : 16'h0000;
        return r;
    endfunction

    task automatic send_req(input mrf_pkg::t_req r);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_device_address   <= r.device_address;
        i_function_code    <= r.function_code;
        i_register_address <= r.register_address;
        i_register_value   <= r.register_value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_req(random_req());
    endtask

    initial begin
        sb                 = new();
        cycles             = 0;
        in_idle_pct        = 0;
        out_stall_pct      = 0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_out_stall        = 1'b0;
        i_device_address   = '0;
        i_function_code    = '0;
        i_register_address = '0;
        i_register_value   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, reads, writes and arbitrary codes passed through
        send_req(make_req(8'h00, 8'h00, 16'h0000, 16'h0000));
        send_req(make_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(8'h01, FnReadHolding, 16'h0000, 16'h0001));
        send_req(make_req(8'h11, FnReadHolding, 16'h006B, 16'h0003));
        send_req(make_req(8'h01, FnWriteSingle, 16'h0001, 16'h0003));
        send_req(make_req(8'hF7, FnWriteSingle, 16'hFFFF, 16'h0000));
        send_req(make_req(8'h01, FnReadInput, 16'h1234, 16'h5678));
        send_req(make_req(8'hFF, FnWriteMulti, 16'h8000, 16'h7FFF));
        send_req(make_req(8'h00, 8'hFF, 16'hAAAA, 16'h5555));
        send_req(make_req(8'h55, 8'hAA, 16'h5555, 16'hAAAA));
        send_req(make_req(8'h80, 8'h01, 16'h0001, 16'h8000));
        send_req(make_req(8'h7F, 8'h80, 16'h7FFF, 16'hFFFF));

        run_phase(0, 0, 55);
        run_phase(51, 0, 50);
        run_phase(0, 51, 50);
        run_phase(38, 38, 55);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d request frames, %0d bytes checked; directed extremes then random",
                 sb.frames_sent, sb.bytes_seen);
        $display("reads, writes and arbitrary codes under four idle/stall mixes, %0d mismatches",
                 sb.mismatches + sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_queue.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer.sv
dv/modbus_rtu_request_framer_test.sv
